/* design/tcl_pkg.sv */
// shared types and constants for the terminal text cell layout block
package tcl_pkg;

	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 256;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int ROW_W = $clog2(MAX_ROWS);

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_BYTE  = 2'd1,
		FUNC_END   = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_CELL  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [ROW_W-1:0]  row;
		logic [7:0]        col;
		logic [31:0]       bytes;
		logic [2:0]        count;
		logic [1:0]        width;
		logic [7:0]        rows_taken;
		logic [7:0]        total_rows;
		logic              last;
	} q_entry_t;

endpackage

/* design/tcl_front.sv */
// front end: escape parsing, utf-8 decoding, wrapping and row tracking
module tcl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [9:0]          cfg_wdata,
	input  logic                in_take,
	input  logic [1:0]          in_func,
	input  logic [7:0]          in_first_row,
	input  logic [7:0]          in_byte,
	output logic [1:0]          push_n,
	output tcl_pkg::q_entry_t   push_e0,
	output tcl_pkg::q_entry_t   push_e1
);

	logic [9:0]  tw_q;
	tcl_pkg::mode_t mode_q, mode_d;
	logic [31:0] pchar_q, pchar_d;
	logic [2:0]  phave_q, phave_d, pneed_q, pneed_d;
	logic [1:0]  pwidth_q, pwidth_d;
	logic [10:0] pcol_q, pcol_d;
	logic [7:0]  row_q, row_d;
	logic [10:0] col_q, col_d;
	logic [7:0]  rcnt_q, rcnt_d;
	logic [7:0]  rowcnt_q, rowcnt_d;
	logic        halted_q, halted_d;

	logic [2:0]  need;
	logic [1:0]  w;
	logic [11:0] col_sum;
	logic [8:0]  row_inc;
	logic [31:0] merged;
	logic        in_char;
	logic        letter;
	logic [10:0] base_col;

	always_comb begin
		mode_d = mode_q;
		pchar_d = pchar_q;
		phave_d = phave_q;
		pneed_d = pneed_q;
		pwidth_d = pwidth_q;
		pcol_d = pcol_q;
		row_d = row_q;
		col_d = col_q;
		rcnt_d = rcnt_q;
		rowcnt_d = rowcnt_q;
		halted_d = halted_q;
		push_n = 2'd0;
		push_e0 = '0;
		push_e1 = '0;

		need = 3'd1;
		w = 2'd1;
		if (in_byte[7] == 1'b0) begin
			need = 3'd1; w = 2'd1;
		end else if ((in_byte & 8'hE0) == 8'hC0) begin
			need = 3'd2; w = 2'd1;
		end else if ((in_byte & 8'hF0) == 8'hE0) begin
			need = 3'd3; w = 2'd2;
		end else if ((in_byte & 8'hF8) == 8'hF0) begin
			need = 3'd4; w = 2'd2;
		end
		col_sum = {1'b0, col_q} + 12'(w);
		row_inc = {1'b0, row_q} + 9'd1;
		merged = pchar_q | (32'(in_byte) << {phave_q[1:0], 3'b000});
		in_char = (phave_q != 3'd0) && (phave_q < pneed_q);
		letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
			((in_byte >= 8'h61) && (in_byte <= 8'h7A));
		base_col = col_q;

		if (in_take) begin
			unique case (tcl_pkg::func_t'(in_func))
				tcl_pkg::FUNC_START: begin
					mode_d = tcl_pkg::MODE_NORMAL;
					pchar_d = '0; phave_d = '0; pneed_d = '0;
					pwidth_d = '0; pcol_d = '0;
					col_d = '0; rcnt_d = '0;
					if ({1'b0, in_first_row} >= 9'(tcl_pkg::MAX_ROWS)) begin
						halted_d = 1'b1;
						push_n = 2'd1;
						push_e0.kind = tcl_pkg::KIND_ERROR;
						push_e0.last = 1'b1;
					end else begin
						halted_d = 1'b0;
						row_d = in_first_row;
						if (in_first_row >= rowcnt_q)
							rowcnt_d = in_first_row + 8'd1;
					end
				end
				tcl_pkg::FUNC_END: begin
					if (!halted_q && in_char) begin
						// truncated character goes out first, missing bytes zero
						if (pcol_q < 11'(tcl_pkg::MAX_COLS)) begin
							push_e0.kind = tcl_pkg::KIND_CELL;
							push_e0.row = row_q[tcl_pkg::ROW_W-1:0];
							push_e0.col = pcol_q[7:0];
							push_e0.bytes = pchar_q;
							push_e0.count = pneed_q;
							push_e0.width = pwidth_q;
							push_e1.kind = tcl_pkg::KIND_DONE;
							push_e1.rows_taken = rcnt_q + {7'd0, col_q != 11'd0};
							push_e1.total_rows = rowcnt_q;
							push_e1.last = 1'b1;
							push_n = 2'd2;
						end
					end
					if (push_n == 2'd0) begin
						push_e0.kind = tcl_pkg::KIND_DONE;
						push_e0.rows_taken = rcnt_q + {7'd0, col_q != 11'd0};
						push_e0.total_rows = rowcnt_q;
						push_e0.last = 1'b1;
						push_n = 2'd1;
					end
					pchar_d = '0; phave_d = '0; pneed_d = '0;
					mode_d = tcl_pkg::MODE_NORMAL;
					halted_d = 1'b1;
				end
				tcl_pkg::FUNC_BYTE: begin
					if (!halted_q) begin
						if (in_char) begin
							pchar_d = merged;
							phave_d = phave_q + 3'd1;
							if (phave_q + 3'd1 >= pneed_q) begin
								phave_d = '0; pneed_d = '0; pchar_d = '0;
								if (pcol_q < 11'(tcl_pkg::MAX_COLS)) begin
									push_n = 2'd1;
									push_e0.kind = tcl_pkg::KIND_CELL;
									push_e0.row = row_q[tcl_pkg::ROW_W-1:0];
									push_e0.col = pcol_q[7:0];
									push_e0.bytes = merged;
									push_e0.count = pneed_q;
									push_e0.width = pwidth_q;
									push_e0.last = 1'b1;
								end
							end
						end else if (mode_q == tcl_pkg::MODE_CSI) begin
							if (letter)
								mode_d = tcl_pkg::MODE_NORMAL;
						end else if (mode_q == tcl_pkg::MODE_ESC &&
							in_byte == tcl_pkg::CH_LBRACKET) begin
							mode_d = tcl_pkg::MODE_CSI;
						end else begin
							mode_d = tcl_pkg::MODE_NORMAL;
							if (in_byte == tcl_pkg::CH_ESC) begin
								mode_d = tcl_pkg::MODE_ESC;
							end else if (in_byte == tcl_pkg::CH_NEWLINE ||
								col_sum > {2'b00, tw_q}) begin
								// newline or wrap: next row
								row_d = row_inc[7:0];
								col_d = '0;
								base_col = '0;
								rcnt_d = rcnt_q + 8'd1;
								if (row_inc >= 9'(tcl_pkg::MAX_ROWS))
									halted_d = 1'b1;
								else if (row_inc[7:0] >= rowcnt_q)
									rowcnt_d = row_q + 8'd2;
							end
							if (in_byte != tcl_pkg::CH_ESC &&
								in_byte != tcl_pkg::CH_NEWLINE && !halted_d) begin
								pcol_d = base_col;
								pwidth_d = w;
								col_d = base_col + 11'(w);
								if (need == 3'd1) begin
									phave_d = '0; pneed_d = '0; pchar_d = '0;
									if (base_col < 11'(tcl_pkg::MAX_COLS)) begin
										push_n = 2'd1;
										push_e0.kind = tcl_pkg::KIND_CELL;
										push_e0.row = row_d[tcl_pkg::ROW_W-1:0];
										push_e0.col = base_col[7:0];
										push_e0.bytes = 32'(in_byte);
										push_e0.count = 3'd1;
										push_e0.width = w;
										push_e0.last = 1'b1;
									end
								end else begin
									pchar_d = 32'(in_byte);
									phave_d = 3'd1;
									pneed_d = need;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 10'd80;
			mode_q <= tcl_pkg::MODE_NORMAL;
			pchar_q <= '0;
			phave_q <= '0;
			pneed_q <= '0;
			pwidth_q <= '0;
			pcol_q <= '0;
			row_q <= '0;
			col_q <= '0;
			rcnt_q <= '0;
			rowcnt_q <= '0;
			halted_q <= 1'b0;
		end else begin
			if (cfg_we)
				tw_q <= cfg_wdata;
			mode_q <= mode_d;
			pchar_q <= pchar_d;
			phave_q <= phave_d;
			pneed_q <= pneed_d;
			pwidth_q <= pwidth_d;
			pcol_q <= pcol_d;
			row_q <= row_d;
			col_q <= col_d;
			rcnt_q <= rcnt_d;
			rowcnt_q <= rowcnt_d;
			halted_q <= halted_d;
		end
	end

endmodule

/* design/tcl_queue.sv */
// short result queue between front and back, takes up to two entries a cycle
module tcl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  tcl_pkg::q_entry_t   push_e0,
	input  tcl_pkg::q_entry_t   push_e1,
	output logic                room2,
	input  logic                pop,
	output logic                not_empty,
	output tcl_pkg::q_entry_t   head
);

	tcl_pkg::q_entry_t mem_q [tcl_pkg::QDEPTH];
	logic [tcl_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [tcl_pkg::QPTR_W:0]   cnt_q;
	logic [tcl_pkg::QPTR_W-1:0] wr1;

	assign wr1 = wr_q + tcl_pkg::QPTR_W'(1);
	assign not_empty = cnt_q != '0;
	assign room2 = cnt_q <= (tcl_pkg::QPTR_W+1)'(tcl_pkg::QDEPTH - 2);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= push_e0;
		if (push_n == 2'd2)
			mem_q[wr1] <= push_e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + tcl_pkg::QPTR_W'(push_n);
			if (pop)
				rd_q <= rd_q + tcl_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + (tcl_pkg::QPTR_W+1)'(push_n) -
				(tcl_pkg::QPTR_W+1)'(pop);
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (tcl_pkg::QPTR_W+1)'(tcl_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room2)
		else $error("push without room");
`endif

endmodule

/* design/tcl_back.sv */
// back end: row length memory update and registered result output
module tcl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  tcl_pkg::q_entry_t   q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output tcl_pkg::q_entry_t   out_e,
	output logic [8:0]          out_len
);

	logic [8:0] len_mem [tcl_pkg::MAX_ROWS];
	logic [tcl_pkg::MAX_ROWS-1:0] vld_q;

	logic               s1_valid_q;
	tcl_pkg::q_entry_t  s1_e_s1;
	logic [8:0]         rd_data_s1;
	logic               rd_vld_s1;
	logic               byp_s1;
	logic [8:0]         byp_len_s1;

	logic               out_valid_q;
	tcl_pkg::q_entry_t  out_e_q;
	logic [8:0]         out_len_q;

	logic       s1_adv;
	logic       s1_cell;
	logic [8:0] old_len, new_len, col_p1;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);
	assign q_pop = q_not_empty && (!s1_valid_q || s1_adv);
	assign s1_cell = s1_e_s1.kind == tcl_pkg::KIND_CELL;
	assign old_len = byp_s1 ? byp_len_s1 : (rd_vld_s1 ? rd_data_s1 : 9'd0);
	assign col_p1 = {1'b0, s1_e_s1.col} + 9'd1;
	assign new_len = (col_p1 > old_len) ? col_p1 : old_len;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_data_s1 <= len_mem[q_head.row];
			s1_e_s1 <= q_head;
			// same row leaving s1 this cycle: take the fresh length
			byp_s1 <= s1_adv && s1_cell && (s1_e_s1.row == q_head.row);
			byp_len_s1 <= new_len;
		end
		if (s1_adv && s1_cell)
			len_mem[s1_e_s1.row] <= new_len;
		if (s1_adv) begin
			out_e_q <= s1_e_s1;
			out_len_q <= s1_cell ? new_len : 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				rd_vld_s1 <= vld_q[q_head.row];
			if (s1_adv && s1_cell)
				vld_q[s1_e_s1.row] <= 1'b1;
			if (q_pop)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_e = out_e_q;
	assign out_len = out_len_q;

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_len_q))
		else $error("stalled result changed");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_e_q.kind == tcl_pkg::KIND_CELL) |->
		(out_len_q > {1'b0, out_e_q.col}))
		else $error("line length below cell column");
	a_s1_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s1_valid_q) |-> $past(q_not_empty))
		else $error("stage one filled without queue entry");
`endif

endmodule

/* design/terminal_text_cell_layout.sv */
// top level of the terminal text cell layout block
// Lays a byte stream out as terminal cells. For every input item taken,
// the front end updates the cursor, escape parser and pending utf-8 character
// in one step and places up to two results in a four-entry queue, so s_tready stays
// high while the queue has room for two. The back end reads the 128-entry row length
// memory a stage ahead of its update (same-row results are forwarded) and delivers one
// result a cycle through a registered output while m_tready is high, so the sustained
// rate is one item per cycle unless an end item with a truncated character adds a second result.
// Row lengths start at zero after reset through per-row valid bits; no clearing pass.
module terminal_text_cell_layout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,      // wrap width in columns
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // first row, text byte
	input  logic [1:0]  s_tuser,       // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,       // cell_row, cell_col, cell_bytes, byte_count,
	                                   // cell_width, line_length, rows taken,
	                                   // total_rows, zero pad
	output logic [1:0]  m_tuser,       // kind
	output logic        m_tlast        // last
);

	logic [1:0]         push_n;
	tcl_pkg::q_entry_t  push_e0, push_e1, q_head, out_e;
	logic               room2, q_pop, q_not_empty;
	logic [8:0]         out_len;

	assign cfg_ready = 1'b1;
	assign s_tready = room2;

	tcl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready), .cfg_wdata(cfg_data),
		.in_take(s_tvalid && s_tready), .in_func(s_tuser),
		.in_first_row(s_tdata[7:0]), .in_byte(s_tdata[15:8]),
		.push_n(push_n), .push_e0(push_e0), .push_e1(push_e1)
	);

	tcl_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_n(push_n), .push_e0(push_e0), .push_e1(push_e1),
		.room2(room2), .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
	);

	tcl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_not_empty(q_not_empty), .q_head(q_head), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_e(out_e), .out_len(out_len)
	);

	assign m_tuser = out_e.kind;
	assign m_tlast = out_e.last;
	assign m_tdata = {3'b000, out_e.total_rows, out_e.rows_taken, out_len,
		out_e.width, out_e.count, out_e.bytes, out_e.col, out_e.row};

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the terminal text cell layout block
module tb_top;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		tcl_pkg::kind_t kind;
		logic [6:0]  row;
		logic [7:0]  col;
		logic [31:0] bytes;
		logic [2:0]  count;
		logic [1:0]  width;
		logic [8:0]  line_len;
		logic [7:0]  rows_taken;
		logic [7:0]  total_rows;
		logic        last;
	} cell_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [9:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	terminal_text_cell_layout dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// layout predictor state
	int unsigned term_width;
	tcl_pkg::mode_t esc_mode;
	int unsigned part_char;
	int unsigned part_have;
	int unsigned part_need;
	int unsigned part_width;
	int unsigned part_col;
	int unsigned cur_row;
	int unsigned cur_col;
	int unsigned rows_used;
	int unsigned screen_rows;
	int unsigned line_len[tcl_pkg::MAX_ROWS];
	bit          halted;

	cell_result_t expected_cells[$];
	int          errors;
	int          items_sent;
	int          results_seen;
	int          widths_used;
	bit          no_idle;
	int          rdy_hold;
	int          idle_cycles;

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic void push_cell(int unsigned cnt, bit last);
		cell_result_t e;
		int unsigned c;
		int unsigned r;
		c = part_col;
		r = cur_row;
		part_have = 0;
		part_need = 0;
		if (c >= tcl_pkg::MAX_COLS || r >= tcl_pkg::MAX_ROWS) begin
			part_char = 0;
			return;
		end
		if (c >= line_len[r])
			line_len[r] = c + 1;
		e = '{kind: tcl_pkg::KIND_CELL, row: r[6:0], col: c[7:0], bytes: part_char,
			count: cnt[2:0], width: part_width[1:0], line_len: line_len[r][8:0],
			rows_taken: 8'd0, total_rows: 8'd0, last: last};
		expected_cells.push_back(e);
		part_char = 0;
	endfunction

	function automatic void advance_row();
		cur_row++;
		cur_col = 0;
		rows_used++;
		if (cur_row >= tcl_pkg::MAX_ROWS) begin
			halted = 1;
			return;
		end
		if (cur_row >= screen_rows)
			screen_rows = cur_row + 1;
	endfunction

	function automatic void place_char(logic [7:0] b);
		int unsigned need;
		int unsigned w;
		need = 1;
		w = 1;
		if (b[7] == 1'b0) begin
			need = 1;
		end else if ((b & 8'hE0) == 8'hC0) begin
			need = 2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			need = 3;
			w = 2;
		end else if ((b & 8'hF8) == 8'hF0) begin
			need = 4;
			w = 2;
		end
		if (cur_col + w > term_width) begin
			advance_row();
			if (halted)
				return;
		end
		part_char = 32'(b);
		part_have = 1;
		part_need = need;
		part_width = w;
		part_col = cur_col;
		cur_col += w;
		if (need == 1)
			push_cell(1, 1'b1);
	endfunction

	function automatic void predict_layout(tcl_pkg::func_t f, logic [7:0] srow,
		logic [7:0] b);
		cell_result_t e;
		int unsigned radd;
		case (f)
			tcl_pkg::FUNC_START: begin
				esc_mode = tcl_pkg::MODE_NORMAL;
				part_char = 0;
				part_have = 0;
				part_need = 0;
				part_width = 0;
				part_col = 0;
				cur_col = 0;
				rows_used = 0;
				if (srow >= tcl_pkg::MAX_ROWS) begin
					halted = 1;
					e = '{kind: tcl_pkg::KIND_ERROR, row: '0, col: '0, bytes: '0,
						count: '0, width: '0, line_len: '0, rows_taken: '0,
						total_rows: '0, last: 1'b1};
					expected_cells.push_back(e);
				end else begin
					halted = 0;
					cur_row = 32'(srow);
					if (srow >= screen_rows)
						screen_rows = srow + 1;
				end
			end
			tcl_pkg::FUNC_END: begin
				// a truncated character is flushed before the counts
				if (!halted && part_have > 0 && part_have < part_need)
					push_cell(part_need, 1'b0);
				part_char = 0;
				part_have = 0;
				part_need = 0;
				esc_mode = tcl_pkg::MODE_NORMAL;
				halted = 1;
				radd = rows_used + (cur_col > 0 ? 1 : 0);
				e = '{kind: tcl_pkg::KIND_DONE, row: '0, col: '0, bytes: '0, count: '0,
					width: '0, line_len: '0, rows_taken: radd[7:0],
					total_rows: screen_rows[7:0], last: 1'b1};
				expected_cells.push_back(e);
			end
			tcl_pkg::FUNC_BYTE: begin
				if (halted)
					return;
				if (part_have > 0 && part_have < part_need) begin
					part_char |= int'(b) << (8 * (part_have & 3));
					part_have++;
					if (part_have >= part_need)
						push_cell(part_need, 1'b1);
					return;
				end
				if (esc_mode == tcl_pkg::MODE_CSI) begin
					if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
						esc_mode = tcl_pkg::MODE_NORMAL;
					return;
				end
				if (esc_mode == tcl_pkg::MODE_ESC) begin
					if (b == tcl_pkg::CH_LBRACKET) begin
						esc_mode = tcl_pkg::MODE_CSI;
						return;
					end
					esc_mode = tcl_pkg::MODE_NORMAL;
				end
				if (b == tcl_pkg::CH_ESC)
					esc_mode = tcl_pkg::MODE_ESC;
				else if (b == tcl_pkg::CH_NEWLINE)
					advance_row();
				else
					place_char(b);
			end
			default: ;
		endcase
	endfunction

	// one input item; we are just after a rising edge on entry
	task automatic send_item(tcl_pkg::func_t f, logic [7:0] srow, logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {b, srow};
		do @(posedge clk); while (!s_tready);
		predict_layout(f, srow, b);
		items_sent++;
	endtask

	task automatic send_text(logic [7:0] b);
		send_item(tcl_pkg::FUNC_BYTE, 8'($urandom), b);
	endtask

	task automatic send_start(logic [7:0] srow);
		send_item(tcl_pkg::FUNC_START, srow, 8'($urandom));
	endtask

	task automatic send_end();
		send_item(tcl_pkg::FUNC_END, 8'($urandom), 8'($urandom));
	endtask

	task automatic set_width(logic [9:0] w);
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		// let any half-built character settle before touching the register
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		term_width = 32'(w);
		widths_used++;
	endtask

	// one random token of text: plain, newline, utf-8, escape or noise
	task automatic send_token(int nl_pct);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < nl_pct) begin
			send_text(tcl_pkg::CH_NEWLINE);
		end else if (r < 45) begin
			send_text(8'($urandom_range(8'h20, 8'h7E)));
		end else if (r < 60) begin
			n = $urandom_range(2, 4);
			case (n)
				2: send_text(8'($urandom_range(8'hC0, 8'hDF)));
				3: send_text(8'($urandom_range(8'hE0, 8'hEF)));
				default: send_text(8'($urandom_range(8'hF0, 8'hF7)));
			endcase
			repeat (n - 1) send_text(8'($urandom_range(8'h80, 8'hBF)));
		end else if (r < 72) begin
			send_text(tcl_pkg::CH_ESC);
			send_text(tcl_pkg::CH_LBRACKET);
			repeat ($urandom_range(0, 3)) send_text(8'($urandom_range("0", "9")));
			send_text(8'($urandom_range("A", "Z") | ($urandom_range(0, 1) << 5)));
		end else if (r < 76) begin
			send_text(tcl_pkg::CH_ESC);
		end else begin
			send_text(8'($urandom));
		end
	endtask

	task automatic test_directed();
		// bytes ahead of any start land on row zero
		send_text("a");
		send_text(tcl_pkg::CH_NEWLINE);
		send_text(8'h00);
		send_item(tcl_pkg::FUNC_NONE, 8'hFF, 8'hFF);
		send_start(8'd0);
		send_text(8'hFF);
		send_text(8'hC3);
		send_text(8'hA9);
		send_text(8'hE2);
		send_text(8'h82);
		send_text(8'hAC);
		send_text(8'hF0);
		send_text(8'h9F);
		send_text(8'h98);
		send_text(8'h80);
		send_text(tcl_pkg::CH_ESC);
		send_text(tcl_pkg::CH_LBRACKET);
		send_text("3");
		send_text("m");
		send_text(tcl_pkg::CH_ESC);
		send_text("z");
		// truncated character is flushed by the end item
		send_text(8'hF4);
		send_text(8'h8F);
		send_end();
		send_text("q");
		send_end();
		send_start(8'd128);
		send_text("x");
		send_end();
		send_start(8'd255);
		send_start(8'd127);
		send_text("y");
		send_end();
	endtask

	task automatic test_wrap_extremes();
		set_width(10'd1);
		send_start(8'd3);
		repeat (6) send_text("w");
		send_text(8'hE3);
		send_text(8'h81);
		send_text(8'h82);
		send_end();
		set_width(10'd0);
		send_start(8'd10);
		repeat (4) send_token(0);
		send_end();
		// row limit through newlines and wraps
		set_width(10'd2);
		send_start(8'd124);
		repeat (20) send_token(15);
		send_end();
		// columns past the cell array
		set_width(10'd1023);
		send_start(8'd40);
		repeat (300) send_text(8'($urandom_range(8'h21, 8'h7E)));
		send_end();
	endtask

	task automatic test_random_text(int target);
		int phase;
		phase = 0;
		while (items_sent < target) begin
			if (phase % 3 == 0) begin
				case ($urandom_range(0, 3))
					0: set_width(10'($urandom_range(1, 12)));
					1: set_width(10'($urandom_range(13, 120)));
					2: set_width(10'($urandom));
					default: set_width(10'd80);
				endcase
			end
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				send_start(8'($urandom_range(128, 255)));
			else if ($urandom_range(0, 5) == 0)
				send_start(8'($urandom_range(110, 127)));
			else
				send_start(8'($urandom_range(0, 30)));
			repeat ($urandom_range(5, 60)) send_token($urandom_range(2, 20));
			if ($urandom_range(0, 3) == 0)
				send_text(8'($urandom_range(8'hC0, 8'hF7)));
			if ($urandom_range(0, 19) == 0)
				send_item(tcl_pkg::FUNC_NONE, 8'($urandom), 8'($urandom));
			if ($urandom_range(0, 9) != 0)
				send_end();
			if ($urandom_range(0, 7) == 0)
				send_text(8'($urandom));
			phase++;
		end
		no_idle = 0;
	endtask

	// output stall pattern
	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			rdy_hold = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		cell_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_cells.size() == 0) begin
				$error("result with nothing expected: kind %0d", m_tuser);
				errors++;
			end else begin
				e = expected_cells.pop_front();
				if (m_tuser !== e.kind) begin
					$error("kind: expected %0d got %0d", e.kind, m_tuser);
					errors++;
				end
				if (m_tdata[6:0] !== e.row) begin
					$error("cell_row: expected %0d got %0d", e.row, m_tdata[6:0]);
					errors++;
				end
				if (m_tdata[14:7] !== e.col) begin
					$error("cell_col: expected %0d got %0d", e.col, m_tdata[14:7]);
					errors++;
				end
				if (m_tdata[46:15] !== e.bytes) begin
					$error("cell_bytes: expected %h got %h", e.bytes, m_tdata[46:15]);
					errors++;
				end
				if (m_tdata[49:47] !== e.count) begin
					$error("byte_count: expected %0d got %0d", e.count, m_tdata[49:47]);
					errors++;
				end
				if (m_tdata[51:50] !== e.width) begin
					$error("cell_width: expected %0d got %0d", e.width, m_tdata[51:50]);
					errors++;
				end
				if (m_tdata[60:52] !== e.line_len) begin
					$error("line_length: expected %0d got %0d", e.line_len,
						m_tdata[60:52]);
					errors++;
				end
				if (m_tdata[68:61] !== e.rows_taken) begin
					$error("rows_taken: expected %0d got %0d", e.rows_taken,
						m_tdata[68:61]);
					errors++;
				end
				if (m_tdata[76:69] !== e.total_rows) begin
					$error("total_rows: expected %0d got %0d", e.total_rows,
						m_tdata[76:69]);
					errors++;
				end
				if (m_tdata[79:77] !== 3'd0) begin
					$error("pad: expected 0 got %0d", m_tdata[79:77]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = tcl_pkg::FUNC_NONE;
		m_tready = 1'b0;
		term_width = 80;
		esc_mode = tcl_pkg::MODE_NORMAL;
		part_char = 0;
		part_have = 0;
		part_need = 0;
		part_width = 0;
		part_col = 0;
		cur_row = 0;
		cur_col = 0;
		rows_used = 0;
		screen_rows = 0;
		halted = 0;
		foreach (line_len[i])
			line_len[i] = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		widths_used = 0;
		no_idle = 0;
		rdy_hold = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wrap_extremes();
		test_random_text(1050);
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d input items and %0d results over %0d width settings",
			items_sent, results_seen, widths_used);
		$display("including escapes, utf-8 widths, truncation, wraps and the row limit");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
design/tcl_pkg.sv
design/tcl_front.sv
design/tcl_queue.sv
design/tcl_back.sv
design/terminal_text_cell_layout.sv
verif/tb_top.sv
